// ----- design/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 61;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DOUBLE_HASH = 1'b0;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COMP, ST_PAD, ST_PADZ, ST_LEN, ST_COMP_F, ST_DBL, ST_COMP_D, ST_OUT
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic       wr_byte;     // write byte into buffer
      logic [7:0] wr_data;
      logic       cnt_inc;
      logic       pad_sel;     // write at pad position (count-based)
      logic       zero_rest;   // zero word w/ index zidx (full word)
      logic [3:0] zidx;
      logic       wr_len;
      logic       load_dbl;    // load first digest as block, reinit
      logic       comp_start;
      logic       init;        // reinit hash and count
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       comp_busy;
      logic       comp_done;
      logic [5:0] pos;
   } dp_sts_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- design/sha256_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding steps, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sha256_pkg::req_payload_type req_payload,
   input  logic                        double_hash,
   input  logic                        out_ready,
   output logic                        out_valid,
   output logic [2:0]                  out_idx,
   output sha256_pkg::dp_cmd_type      cmd,
   input  sha256_pkg::dp_sts_type      sts
);
   import sha256_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          last_ff, last_in;
   logic          dbl_ff, dbl_in;
   logic [3:0]    zidx_ff, zidx_in;
   logic [2:0]    oidx_ff, oidx_in;
   logic          ovalid_ff, ovalid_in;

   logic acc;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         last_ff   <= 1'b0;
         dbl_ff    <= 1'b0;
         zidx_ff   <= '0;
         oidx_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         dbl_ff    <= dbl_in;
         zidx_ff   <= zidx_in;
         oidx_ff   <= oidx_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      dbl_in    = dbl_ff;
      zidx_in   = zidx_ff;
      oidx_in   = oidx_ff;
      ovalid_in = ovalid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               last_in = req_payload.last_byte;
               dbl_in  = double_hash;
               if (req_payload.has_byte && sts.pos == 6'd63) state_in = ST_COMP;
               else if (req_payload.last_byte)               state_in = ST_PAD;
            end
         end
         ST_COMP: if (sts.comp_done) state_in = last_ff ? ST_PAD : ST_IDLE;
         ST_PAD: begin
            zidx_in  = {1'b0, sts.pos[5:2]} == 5'd15 ? 4'd15 : sts.pos[5:2] + 4'd1;
            state_in = (sts.pos[5:2] == 4'd15) ? ST_LEN : ST_PADZ;
         end
         ST_PADZ: begin
            zidx_in = zidx_ff + 4'd1;
            if (zidx_ff == 4'd15) state_in = ST_LEN;
         end
         ST_LEN: begin
            // pos counts bytes before padding; pad overflow needs an extra block
            state_in = ST_COMP_F;
         end
         ST_COMP_F: begin
            if (sts.comp_done) begin
               if (sts.pos >= LEN_POS) begin
                  // first of two padding blocks done; zero whole block
                  zidx_in  = 4'd0;
                  state_in = ST_PADZ;
               end else if (dbl_ff) begin
                  state_in = ST_DBL;
               end else begin
                  state_in  = ST_OUT;
                  oidx_in   = '0;
                  ovalid_in = 1'b1;
               end
            end
         end
         ST_DBL: state_in = ST_COMP_D;
         ST_COMP_D: begin
            if (sts.comp_done) begin
               state_in  = ST_OUT;
               oidx_in   = '0;
               ovalid_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  ovalid_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      out_valid = ovalid_ff;
      out_idx   = oidx_ff;
      cmd.wr_data = req_payload.data_byte;
      cmd.zidx    = zidx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_byte    = acc && req_payload.has_byte;
            cmd.cnt_inc    = acc && req_payload.has_byte;
            cmd.comp_start = acc && req_payload.has_byte && sts.pos == 6'd63;
         end
         ST_PAD:  cmd.pad_sel = 1'b1;
         ST_PADZ: cmd.zero_rest = 1'b1;
         ST_LEN: begin
            cmd.wr_len     = (sts.pos < LEN_POS);
            cmd.comp_start = 1'b1;
         end
         ST_COMP_F: begin
            // second padding block: after zeroing, length goes in via ST_LEN
         end
         ST_DBL: begin
            cmd.load_dbl   = 1'b1;
            cmd.comp_start = 1'b1;
         end
         ST_OUT:  cmd.init = out_ready && oidx_ff == 3'd7;
         default: ;
      endcase
   end

endmodule

// ----- design/sha256_dp.sv -----
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block buffer, message schedule, round unit, hash state, count.
// ----------------------------------------------------------------------------
module sha256_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   output sha256_pkg::dp_sts_type sts,
   input  logic [2:0]             out_idx,
   output logic [31:0]            out_word
);
   import sha256_pkg::*;

   logic [31:0]        blk_ff [16];
   logic [31:0]        blk_in [16];
   logic [31:0]        w_ff [16];
   logic [31:0]        w_in [16];
   logic [31:0]        h_ff [8];
   logic [31:0]        h_in [8];
   logic [31:0]        v_ff [8];
   logic [31:0]        v_in [8];
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               lock_ff, lock_in;   // padding started, length not yet written
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic               padded_ff, padded_in;  // second pad block pending

   logic [5:0]  pos;
   logic [63:0] bits;
   logic [31:0] s0, s1, wnext, t1, t2, a, e;

   // position of the next byte; frozen after pad overflow
   assign pos  = cnt_ff[5:0];
   assign bits = {cnt_ff, 3'b000};

   assign sts.comp_busy = busy_ff;
   assign sts.comp_done = done_ff;
   assign sts.pos       = padded_ff ? 6'd0 : pos;
   assign out_word      = h_ff[out_idx];

   always_comb begin
      a  = v_ff[0];
      e  = v_ff[4];
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnext = s1 + w_ff[9] + s0 + w_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[rnd_ff] + w_ff[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      blk_in    = blk_ff;
      w_in      = w_ff;
      v_in      = v_ff;
      h_in      = h_ff;
      cnt_in    = cnt_ff;
      lock_in   = lock_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rnd_in    = rnd_ff;
      padded_in = padded_ff;
      if (cmd.wr_byte)
         blk_in[pos[5:2]][8*(3-pos[1:0]) +: 8] = cmd.wr_data;
      if (cmd.cnt_inc) cnt_in = cnt_ff + COUNT_W'(1);
      if (cmd.pad_sel) begin
         if (!padded_ff) begin
            blk_in[pos[5:2]][8*(3-pos[1:0]) +: 8] = PAD_BYTE;
            for (int k = 0; k < 4; k++)
               if (k > 32'(pos[1:0])) blk_in[pos[5:2]][8*(3-k) +: 8] = 8'h00;
         end
      end
      if (cmd.zero_rest) blk_in[cmd.zidx] = '0;
      if (cmd.wr_len || padded_ff && cmd.comp_start && !cmd.load_dbl) begin
         blk_in[14] = bits[63:32];
         blk_in[15] = bits[31:0];
      end
      if (cmd.load_dbl) begin
         for (int k = 0; k < 8; k++) begin
            blk_in[k] = h_ff[k];
            h_in[k]   = INIT_H[k];
         end
         blk_in[8] = 32'h80000000;
         for (int k = 9; k < 15; k++) blk_in[k] = '0;
         blk_in[15] = 32'd256;
      end
      if (cmd.comp_start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         w_in    = blk_in;
         for (int k = 0; k < 8; k++) v_in[k] = h_in[k];
      end else if (busy_ff) begin
         for (int k = 0; k < 15; k++) w_in[k] = w_ff[k+1];
         w_in[15] = wnext;
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         rnd_in  = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            for (int k = 0; k < 8; k++) h_in[k] = h_ff[k] + v_in[k];
         end
      end
      // final-block bookkeeping; the overflow flag holds until load_dbl or init clears it
      if (done_ff && !cmd.comp_start && pos >= LEN_POS && !padded_ff && lock_ff)
         padded_in = 1'b1;
      else if (cmd.load_dbl || cmd.init) padded_in = 1'b0;
      if (cmd.pad_sel) lock_in = 1'b1;
      if (cmd.load_dbl || cmd.init || (cmd.comp_start && !cmd.pad_sel
            && (cmd.wr_len || padded_ff))) lock_in = 1'b0;
      if (cmd.init) begin
         for (int k = 0; k < 8; k++) h_in[k] = INIT_H[k];
         cnt_in = '0;
      end
      if (cmd.load_dbl) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) h_ff[k] <= INIT_H[k];
         cnt_ff    <= '0;
         lock_ff   <= 1'b0;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         rnd_ff    <= '0;
         padded_ff <= 1'b0;
      end else begin
         h_ff      <= h_in;
         cnt_ff    <= cnt_in;
         lock_ff   <= lock_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         rnd_ff    <= rnd_in;
         padded_ff <= padded_in;
      end
      blk_ff <= blk_in;
      w_ff   <= w_in;
      v_ff   <= v_in;
   end

endmodule

// ----- design/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256 / SHA-256d hasher with an APB-style control port.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat carries one message byte (has_byte) and an end
//    flag (last_byte). A beat with neither flag set is ignored.
//  - rsp_ channel: after a last_byte beat, eight beats carry the digest,
//    word_index 0 (most significant) first, last_word on the eighth.
//  - csr_ port: register 0 at address 0, bit 0 = double_hash, sampled when
//    the final beat is taken.
// Flow: byte beats are taken only while idle; the 64th byte of a block starts
//   the one-round-per-cycle compression loop, and no beat is taken until it
//   ends. Finishing costs the padding steps (a second block when the length
//   spills over) plus one or two compressions, one more (after a load step)
//   with double_hash, then eight output beats.
// Reset restores the initial hash and clears the byte count.
// A stalled rsp_ beat holds its word; no req_ beat is taken until all eight
//   digest beats are gone.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sha256_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sha256_pkg::rsp_payload_type rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sha256_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import sha256_pkg::*;

   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic        dbl_ff;
   logic [2:0]  out_idx;
   logic [31:0] out_word;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) dbl_ff <= 1'b0;
      else if (psel && penable && pwrite && paddr == CSR_DOUBLE_HASH) dbl_ff <= pwdata[0];
   end
   assign prdata = (paddr == CSR_DOUBLE_HASH) ? {31'd0, dbl_ff} : '0;

   sha256_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .double_hash(dbl_ff), .out_ready(rsp_ready), .out_valid(rsp_valid),
      .out_idx, .cmd, .sts);

   sha256_dp u_dp (.clock, .reset, .cmd, .sts, .out_idx, .out_word);

   assign rsp_payload.digest_word = out_word;
   assign rsp_payload.word_index  = out_idx;
   assign rsp_payload.last_word   = (out_idx == 3'd7);

endmodule

// ----- design/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input sha256_pkg::rsp_payload_type rsp_payload
);
   import sha256_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during digest");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_word == (rsp_payload.word_index == 3'd7)))
      else $error("last_word mismatch");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_word |=>
      rsp_valid && rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1)
      else $error("digest word skipped");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled beat changed");
endmodule

bind sha256_stream_hasher sha256_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_payload);

// ----- tb/sv/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the byte and digest channels and the control writes, keeps its own
// SHA-256 / SHA-256d state and compares every digest beat in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  sha256_pkg::req_payload_type req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  sha256_pkg::rsp_payload_type rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sha256_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          pending_words
);
   import sha256_pkg::*;

   logic [31:0]        chain[8];
   logic [31:0]        blk[16];
   logic [COUNT_W-1:0] nbytes;
   logic               dbl_mode;
   rsp_payload_type    digest_q[$];

   function automatic logic [31:0] rr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
         w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic put_byte(int pos, logic [7:0] b);
      int sh;
      sh = (3 - (pos % 4)) * 8;
      blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(b) << sh);
   endtask

   task automatic restart();
      for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
      nbytes = '0;
   endtask

   // one accepted byte beat -> zero or eight expected digest words
   task automatic hash_beat(req_payload_type p);
      int          pos;
      logic [63:0] bits;
      rsp_payload_type r;
      logic [31:0] first[8];
      if (p.has_byte) begin
         pos = int'(nbytes[5:0]);
         put_byte(pos, p.data_byte);
         nbytes++;
         if (pos == 63) compress_block();
      end
      if (!p.last_byte) return;
      pos  = int'(nbytes[5:0]);
      bits = {3'b0, nbytes} << 3;
      put_byte(pos, PAD_BYTE);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      if (pos >= int'(LEN_POS)) begin
         compress_block();
         for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress_block();
      if (dbl_mode) begin
         for (int i = 0; i < 8; i++) first[i] = chain[i];
         restart();
         for (int i = 0; i < 8; i++) blk[i] = first[i];
         blk[8] = 32'h8000_0000;
         for (int i = 9; i < 15; i++) blk[i] = '0;
         blk[15] = 32'd256;
         compress_block();
      end
      for (int i = 0; i < 8; i++) begin
         r.digest_word = chain[i];
         r.word_index  = 3'(i);
         r.last_word   = (i == 7);
         digest_q.push_back(r);
      end
      restart();
   endtask

   always @(posedge clock) begin
      rsp_payload_type e;
      if (reset) begin
         dbl_mode = 1'b0;
         for (int i = 0; i < 16; i++) blk[i] = '0;
         restart();
         digest_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_DOUBLE_HASH)
            dbl_mode = pwdata[0];
         if (req_valid && req_ready) hash_beat(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $error("digest beat with nothing expected: %h", rsp_payload);
               fail_count++;
            end else begin
               e = digest_q.pop_front();
               if (rsp_payload.digest_word !== e.digest_word) begin
                  $error("digest_word exp %h got %h", e.digest_word,
                         rsp_payload.digest_word);
                  fail_count++;
               end
               if (rsp_payload.word_index !== e.word_index) begin
                  $error("word_index exp %0d got %0d", e.word_index,
                         rsp_payload.word_index);
                  fail_count++;
               end
               if (rsp_payload.last_word !== e.last_word) begin
                  $error("last_word exp %b got %b", e.last_word,
                         rsp_payload.last_word);
                  fail_count++;
               end
            end
         end
      end
      pending_words = digest_q.size();
   end

endmodule

// ----- tb/sv/tb_sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives byte messages and mode writes into the hasher; the digest checker
// beside it predicts and compares every digest beat.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
   import sha256_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;
   int              fail_count, pending_words;
   int              cycles = 0;
   bit              calm = 1'b0;   // no idling on either side while set

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sha256_stream_hasher DUT (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

   sha256_digest_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending_words);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // digest side: ready drops in ~35% of cycles unless calm
   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 35);

   // one byte beat; random idle gap first, then hold until taken.
   // valid stays up after the handshake; the next beat, an idle cycle or
   // drain() takes it down at the following falling edge
   task automatic send_beat(logic [7:0] b, logic hb, logic lb);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= '{data_byte: b, has_byte: hb, last_byte: lb};
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // message of len bytes; empty messages end on a bare end marker
   task automatic send_message(int len, bit pattern);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = pattern ? 8'(i * 37 + 1) : 8'($urandom_range(255));
         if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(b, 1'b1, (i == len - 1) ? 1'($urandom_range(1)) : 1'b0);
         if (i == len - 1 && req_payload.last_byte == 1'b0) continue;
      end
      // close unless the final byte already carried the end flag
      if (len == 0 || !req_payload.last_byte)
         send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   // wait until all digest words are out, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(logic dbl);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= CSR_DOUBLE_HASH;
      pwdata <= {$urandom} & ~32'h1 | 32'(dbl);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   initial begin
      int sent;
      int len;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty, one byte, short messages, idle beats, both modes
      write_mode(1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b1);
      send_message(3, 1'b1);
      drain();
      write_mode(1'b1);
      send_beat(8'h5a, 1'b0, 1'b1);
      send_beat(8'ha5, 1'b1, 1'b1);
      send_message(5, 1'b0);
      drain();

      // random: mostly short messages, a few across the padding boundary
      sent = 0;
      while (sent < 320) begin
         if ($urandom_range(9) == 0) begin
            drain();
            write_mode(1'($urandom_range(1)));
         end
         calm = (sent > 140 && sent < 200);
         case ($urandom_range(9))
            0:       len = 0;
            1, 2:    len = $urandom_range(55, 64);
            3:       len = $urandom_range(100, 130);
            default: len = $urandom_range(1, 12);
         endcase
         send_message(len, 1'b0);
         sent += len + 1;
      end
      calm = 1'b0;
      drain();
      write_mode(1'b0);
      send_message(56, 1'b1);
      drain();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/sha256_pkg.sv
design/sha256_ctrl.sv
design/sha256_dp.sv
design/sha256_stream_hasher.sv
design/sha256_checker.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_sha256_stream_hasher.sv
